// ----- hw/rtl/stsp_pkg.sv -----
`timescale 1ns / 1ps

package stsp_pkg;

	// Field widths of the channels
	localparam int FUNC_W      = 3;
	localparam int ADDR_W      = 12;
	localparam int SAMPLE_W    = 16;
	localparam int ACC_W       = 32;
	localparam int COUNT_W     = 13;
	localparam int GAIN_CODE_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	// Gain is 1024 * 10^(h/40); the largest 8-bit code needs 21 bits
	localparam int GAIN_W    = 21;
	localparam int FRAC_BITS = 10;

	localparam int SAMPLE_DEPTH_DEFAULT = 4096;
	localparam int QUEUE_DEPTH_DEFAULT  = 2;

	// Q32 step factors for +0.5 dB and -0.5 dB
	localparam logic [63:0] STEP_UP_Q32   = 64'd4549460108;
	localparam logic [63:0] STEP_DOWN_Q32 = 64'd4054710589;
	localparam logic [63:0] LOW32         = 64'h0000_0000_FFFF_FFFF;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 3'd0,
		FUNC_PLAY  = 3'd1,
		FUNC_STOP  = 3'd2,
		FUNC_TICK  = 3'd3,
		FUNC_MIX   = 3'd4
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SAMPLE_COUNT = 3'd0,
		CFG_LOOP_ENABLE  = 3'd1,
		CFG_MUTE_ENABLE  = 3'd2,
		CFG_GAIN_LEFT    = 3'd3,
		CFG_GAIN_RIGHT   = 3'd4
	} cfg_index_t;

	// What the back end does to the current samples
	typedef enum logic [1:0] {
		FETCH_NONE = 2'd0,
		FETCH_MEM  = 2'd1,
		FETCH_ZERO = 2'd2
	} fetch_t;

	// One classified item in the queue
	typedef struct packed {
		func_t                       op;
		logic                        wr_ok;
		logic [ADDR_W-1:0]           address;
		logic signed [SAMPLE_W-1:0]  left_value;
		logic signed [SAMPLE_W-1:0]  right_value;
		logic signed [ACC_W-1:0]     mix_in_left;
		logic signed [ACC_W-1:0]     mix_in_right;
	} item_t;

	// Settled configuration seen by the back end
	typedef struct packed {
		logic              loop_enable;
		logic              mute_enable;
		logic [GAIN_W-1:0] gain_left;
		logic [GAIN_W-1:0] gain_right;
	} cfg_t;

	typedef logic [(1 << GAIN_CODE_W)-1:0][GAIN_W-1:0] gain_rom_t;

	// Width of the effective length: holds the sample count and the depth
	function automatic int len_w(int depth);
		int aw1;
		aw1 = $clog2(depth) + 1;
		return (aw1 > COUNT_W) ? aw1 : COUNT_W;
	endfunction

	// Repeated Q32 multiply by the half-dB step, then round to integer
	function automatic logic [GAIN_W-1:0] gain_from_code(logic [GAIN_CODE_W-1:0] code);
		logic [63:0] acc;
		logic [63:0] step;
		logic [63:0] ah;
		logic [63:0] al;
		logic [63:0] bh;
		logic [63:0] bl;
		int          n;
		acc  = 64'd1024 << 32;
		step = code[GAIN_CODE_W-1] ? STEP_DOWN_Q32 : STEP_UP_Q32;
		n    = code[GAIN_CODE_W-1] ? ((1 << GAIN_CODE_W) - int'(code)) : int'(code);
		bh   = step >> 32;
		bl   = step & LOW32;
		for (int i = 0; i < (1 << (GAIN_CODE_W - 1)); i++) begin
			if (i < n) begin
				ah  = acc >> 32;
				al  = acc & LOW32;
				acc = ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
			end
		end
		return GAIN_W'((acc + 64'h0000_0000_8000_0000) >> 32);
	endfunction

	function automatic gain_rom_t build_gain_rom();
		gain_rom_t rom;
		for (int c = 0; c < (1 << GAIN_CODE_W); c++) begin
			rom[c] = gain_from_code(GAIN_CODE_W'(c));
		end
		return rom;
	endfunction

	localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

// ----- hw/rtl/stsp_if.sv -----
`timescale 1ns / 1ps

// Command channel into the player
interface stsp_req_if;
	logic                                     valid;
	logic                                     ready;
	logic [stsp_pkg::FUNC_W-1:0]              func;
	logic [stsp_pkg::ADDR_W-1:0]              address;
	logic signed [stsp_pkg::SAMPLE_W-1:0]     left_value;
	logic signed [stsp_pkg::SAMPLE_W-1:0]     right_value;
	logic signed [stsp_pkg::ACC_W-1:0]        mix_in_left;
	logic signed [stsp_pkg::ACC_W-1:0]        mix_in_right;

	modport source (output valid, func, address, left_value, right_value,
		mix_in_left, mix_in_right, input ready);
	modport sink (input valid, func, address, left_value, right_value,
		mix_in_left, mix_in_right, output ready);
endinterface

// Mixed frame out of the player
interface stsp_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [stsp_pkg::ACC_W-1:0]   mix_out_left;
	logic signed [stsp_pkg::ACC_W-1:0]   mix_out_right;
	logic                                active;

	modport source (output valid, mix_out_left, mix_out_right, active, input ready);
	modport sink (input valid, mix_out_left, mix_out_right, active, output ready);
endinterface

// Register write channel
interface stsp_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [stsp_pkg::CFG_INDEX_W-1:0]     index;
	logic [stsp_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/stsp_queue.sv -----
`timescale 1ns / 1ps

module stsp_queue #(
	parameter int DEPTH = stsp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stsp_pkg::item_t push_item,
	output logic            full,
	output logic            head_valid,
	input  logic            pop_ready,
	output stsp_pkg::item_t head_item
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	stsp_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign pop        = head_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/stsp_front.sv -----
`timescale 1ns / 1ps

module stsp_front #(
	parameter int SAMPLE_DEPTH = stsp_pkg::SAMPLE_DEPTH_DEFAULT
) (
	stsp_req_if.sink        req,
	input  logic            q_full,
	output logic            push,
	output stsp_pkg::item_t item
);

	logic known;

	// Codes past mix are taken and dropped
	assign known    = req.func inside {[stsp_pkg::FUNC_WRITE : stsp_pkg::FUNC_MIX]};
	assign req.ready = !q_full;
	assign push     = req.valid && !q_full && known;

	// Classify the transaction for the back end
	always_comb begin
		item.op           = stsp_pkg::func_t'(req.func);
		item.wr_ok        = (int'(req.address) < SAMPLE_DEPTH);
		item.address      = req.address;
		item.left_value   = req.left_value;
		item.right_value  = req.right_value;
		item.mix_in_left  = req.mix_in_left;
		item.mix_in_right = req.mix_in_right;
	end

endmodule

// ----- hw/rtl/stsp_cfg.sv -----
`timescale 1ns / 1ps

module stsp_cfg #(
	parameter int SAMPLE_DEPTH = stsp_pkg::SAMPLE_DEPTH_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	stsp_cfg_if.sink                                cfg,
	output stsp_pkg::cfg_t                          regs,
	output logic [stsp_pkg::len_w(SAMPLE_DEPTH)-1:0] eff_len
);

	localparam int LW = stsp_pkg::len_w(SAMPLE_DEPTH);

	stsp_pkg::cfg_t regs_q;
	logic [LW-1:0]  eff_len_q;
	logic [LW-1:0]  count_ext;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;
	assign eff_len   = eff_len_q;
	assign count_ext = LW'(cfg.data);

	// Register writes; the sample count is clamped to the depth here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q          <= '0;
			regs_q.loop_enable <= 1'b0;
			regs_q.mute_enable <= 1'b0;
			regs_q.gain_left   <= stsp_pkg::GAIN_ROM[0];
			regs_q.gain_right  <= stsp_pkg::GAIN_ROM[0];
		end else if (cfg.valid) begin
			case (stsp_pkg::cfg_index_t'(cfg.index))
				stsp_pkg::CFG_SAMPLE_COUNT: begin
					eff_len_q <= (count_ext > LW'(SAMPLE_DEPTH)) ? LW'(SAMPLE_DEPTH) : count_ext;
				end
				stsp_pkg::CFG_LOOP_ENABLE: regs_q.loop_enable <= cfg.data[0];
				stsp_pkg::CFG_MUTE_ENABLE: regs_q.mute_enable <= cfg.data[0];
				stsp_pkg::CFG_GAIN_LEFT: begin
					regs_q.gain_left <=
						stsp_pkg::GAIN_ROM[cfg.data[stsp_pkg::GAIN_CODE_W-1:0]];
				end
				stsp_pkg::CFG_GAIN_RIGHT: begin
					regs_q.gain_right <=
						stsp_pkg::GAIN_ROM[cfg.data[stsp_pkg::GAIN_CODE_W-1:0]];
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/stsp_back.sv -----
`timescale 1ns / 1ps

module stsp_back #(
	parameter int SAMPLE_DEPTH = stsp_pkg::SAMPLE_DEPTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     q_valid,
	output logic                                     q_ready,
	input  stsp_pkg::item_t                          q_item,
	input  stsp_pkg::cfg_t                           regs,
	input  logic [stsp_pkg::len_w(SAMPLE_DEPTH)-1:0] eff_len,
	stsp_rsp_if.source                               rsp
);

	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int LW = stsp_pkg::len_w(SAMPLE_DEPTH);
	localparam int SW = stsp_pkg::SAMPLE_W;
	localparam int AC = stsp_pkg::ACC_W;
	localparam int PW = SW + stsp_pkg::GAIN_W + 1;
	localparam int FB = stsp_pkg::FRAC_BITS;

	// Scale by gain/1024 truncating toward zero, add and saturate
	function automatic logic signed [AC-1:0] mix_lane(logic signed [PW-1:0] prod,
		logic signed [AC-1:0] acc);
		logic signed [PW-1:0] biased;
		logic signed [PW-1:0] scaled;
		logic signed [AC:0]   sum;
		biased = prod + $signed({{(PW - FB){1'b0}}, {FB{prod[PW-1]}}});
		scaled = biased >>> FB;
		sum    = (AC + 1)'(acc) + (AC + 1)'(scaled);
		if (sum[AC] != sum[AC-1]) begin
			return sum[AC] ? {1'b1, {(AC - 1){1'b0}}} : {1'b0, {(AC - 1){1'b1}}};
		end
		return sum[AC-1:0];
	endfunction

	logic [2*SW-1:0] mem [SAMPLE_DEPTH];

	logic                 adv;
	logic                 pop;
	logic                 len_nz;
	logic [LW-1:0]        pos_next;

	// Play state
	logic                 playing_q;
	logic [AW-1:0]        position_q;
	logic signed [SW-1:0] cur_l_q;
	logic signed [SW-1:0] cur_r_q;

	// Decisions for the head item
	logic                 nxt_playing;
	logic [AW-1:0]        nxt_pos;
	logic [AW-1:0]        rd_addr;
	logic                 mem_we;
	logic                 act;
	stsp_pkg::fetch_t     fetch;

	// Stage 1: memory read, mix control
	logic                 mix_s1;
	logic                 act_s1;
	stsp_pkg::fetch_t     fetch_s1;
	logic [2*SW-1:0]      rdata_s1;
	logic signed [AC-1:0] mix_in_l_s1;
	logic signed [AC-1:0] mix_in_r_s1;

	// Stage 2: products
	logic                 mix_s2;
	logic                 act_s2;
	logic signed [PW-1:0] prod_l_s2;
	logic signed [PW-1:0] prod_r_s2;
	logic signed [AC-1:0] mix_in_l_s2;
	logic signed [AC-1:0] mix_in_r_s2;

	// Output register
	logic                 out_v_q;
	logic signed [AC-1:0] out_l_q;
	logic signed [AC-1:0] out_r_q;
	logic                 out_act_q;

	assign adv      = !out_v_q || rsp.ready;
	assign pop      = adv && q_valid;
	assign q_ready  = adv;
	assign len_nz   = (eff_len != '0);
	assign pos_next = LW'(position_q) + LW'(1);

	assign rsp.valid         = out_v_q;
	assign rsp.mix_out_left  = out_l_q;
	assign rsp.mix_out_right = out_r_q;
	assign rsp.active        = out_act_q;

	// Play control for the item at the head of the queue
	always_comb begin
		nxt_playing = playing_q;
		nxt_pos     = position_q;
		rd_addr     = position_q;
		mem_we      = 1'b0;
		fetch       = stsp_pkg::FETCH_NONE;
		act         = playing_q && !regs.mute_enable;
		if (pop) begin
			case (q_item.op)
				stsp_pkg::FUNC_WRITE: mem_we = q_item.wr_ok;
				stsp_pkg::FUNC_PLAY: begin
					if (len_nz && !playing_q && !regs.mute_enable) begin
						nxt_playing = 1'b1;
						nxt_pos     = '0;
						rd_addr     = '0;
						fetch       = stsp_pkg::FETCH_MEM;
					end
				end
				stsp_pkg::FUNC_STOP: begin
					if (len_nz && playing_q) begin
						nxt_playing = 1'b0;
						fetch       = stsp_pkg::FETCH_ZERO;
					end
				end
				stsp_pkg::FUNC_TICK: begin
					if (playing_q) begin
						if (pos_next < eff_len) begin
							nxt_pos = pos_next[AW-1:0];
							rd_addr = pos_next[AW-1:0];
							fetch   = stsp_pkg::FETCH_MEM;
						end else if (regs.loop_enable) begin
							// wrap; an empty buffer plays silence
							nxt_pos = '0;
							rd_addr = '0;
							fetch   = len_nz ? stsp_pkg::FETCH_MEM : stsp_pkg::FETCH_ZERO;
						end else if (len_nz) begin
							nxt_playing = 1'b0;
							fetch       = stsp_pkg::FETCH_ZERO;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Sample memory, single port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(q_item.address)] <= {q_item.left_value, q_item.right_value};
		end else if (adv) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Play state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= 1'b0;
			position_q <= '0;
			cur_l_q    <= '0;
			cur_r_q    <= '0;
			mix_s1     <= 1'b0;
			fetch_s1   <= stsp_pkg::FETCH_NONE;
			mix_s2     <= 1'b0;
			out_v_q    <= 1'b0;
		end else if (adv) begin
			playing_q  <= nxt_playing;
			position_q <= nxt_pos;
			mix_s1     <= pop && (q_item.op == stsp_pkg::FUNC_MIX);
			fetch_s1   <= fetch;
			mix_s2     <= mix_s1;
			out_v_q    <= mix_s2;
			case (fetch_s1)
				stsp_pkg::FETCH_MEM: begin
					cur_l_q <= rdata_s1[2*SW-1:SW];
					cur_r_q <= rdata_s1[SW-1:0];
				end
				stsp_pkg::FETCH_ZERO: begin
					cur_l_q <= '0;
					cur_r_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1      <= act;
			mix_in_l_s1 <= q_item.mix_in_left;
			mix_in_r_s1 <= q_item.mix_in_right;
			act_s2      <= act_s1;
			mix_in_l_s2 <= mix_in_l_s1;
			mix_in_r_s2 <= mix_in_r_s1;
			prod_l_s2   <= PW'(cur_l_q) * $signed({1'b0, regs.gain_left});
			prod_r_s2   <= PW'(cur_r_q) * $signed({1'b0, regs.gain_right});
			if (mix_s2) begin
				out_act_q <= act_s2;
				out_l_q   <= act_s2 ? mix_lane(prod_l_s2, mix_in_l_s2) : mix_in_l_s2;
				out_r_q   <= act_s2 ? mix_lane(prod_r_s2, mix_in_r_s2) : mix_in_r_s2;
			end
		end
	end

	// Only a mix frame loads the output register
	a_out_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !mix_s2 |=> !out_v_q)
		else $error("result shown without a mix frame");

	// Playback starts only on a play command
	a_play_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(playing_q) |-> $past(pop && q_item.op == stsp_pkg::FUNC_PLAY))
		else $error("playback started without play");

	// A sample write never schedules a fetch
	a_write_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_item.op == stsp_pkg::FUNC_WRITE |=> fetch_s1 == stsp_pkg::FETCH_NONE)
		else $error("write scheduled a fetch");

	// An inactive frame passes the left accumulator through
	a_inactive_pass: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mix_s2 && !act_s2 |=>
		rsp.mix_out_left == $past(mix_in_l_s2) && !rsp.active)
		else $error("inactive frame altered the accumulator");

endmodule

// ----- hw/rtl/stereo_sample_player.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// req      in   valid/ready    func, address, left_value, right_value,
//                              mix_in_left, mix_in_right
// rsp      out  valid/ready    mix_out_left, mix_out_right, active
// cfg      in   valid/ready    index, data (ready always high)
//
// One command per cycle sustained while no result is held on rsp. A mix
// frame reaches rsp through the queue, sample memory read, gain multiply,
// then scale/add/saturate into the output register. Other commands give no result.
// Reset clears play state, config and the pipeline; the sample memory is
// not cleared and needs no clearing pass.
// A held result stalls the back end; the two-entry queue keeps req ready
// until it fills.

module stereo_sample_player #(
	parameter int SAMPLE_DEPTH = stsp_pkg::SAMPLE_DEPTH_DEFAULT,
	parameter int QUEUE_DEPTH  = stsp_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	stsp_req_if.sink    req,
	stsp_rsp_if.source  rsp,
	stsp_cfg_if.sink    cfg
);

	localparam int LW = stsp_pkg::len_w(SAMPLE_DEPTH);

	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            q_ready;
	stsp_pkg::item_t push_item;
	stsp_pkg::item_t head_item;
	stsp_pkg::cfg_t  regs;
	logic [LW-1:0]   eff_len;

	// Accept and classify
	stsp_front #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	// Decoupling queue
	stsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.head_valid (q_valid),
		.pop_ready  (q_ready),
		.head_item  (head_item)
	);

	// Registers and gain lookup
	stsp_cfg #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.eff_len (eff_len)
	);

	// Playback and mixing
	stsp_back #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (head_item),
		.regs    (regs),
		.eff_len (eff_len),
		.rsp     (rsp)
	);

endmodule
